### hw/rtl/msq_pkg.sv
// shared constants for the marching squares cell
`default_nettype none
package msq_pkg;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int GRID_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int IDX_BITS        = 10;
    localparam int COORD_BITS      = 22;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_ISO_LEVEL    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECIDER_MODE = 1'b1;

    localparam logic MODE_MIDPOINT   = 1'b0;
    localparam logic MODE_ASYMPTOTIC = 1'b1;

    // edge codes
    localparam logic [1:0] EDGE_BOTTOM = 2'd0;
    localparam logic [1:0] EDGE_TOP    = 2'd1;
    localparam logic [1:0] EDGE_LEFT   = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;
endpackage
`default_nettype wire

### hw/rtl/msq_if.sv
// valid/ready channel interface with a generic payload
`default_nettype none
interface msq_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/msq_div.sv
// pipelined restoring divider for the edge crossing fraction
`default_nettype none
module msq_div import msq_pkg::*; #(
    parameter int NUM_BITS = 17,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int STEPS_PER_STAGE = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [NUM_BITS-1:0]  i_num,
    input  wire logic [NUM_BITS-1:0]  i_den,
    output logic      [FRAC_BITS:0]   o_quot
);
    // quotient saturates at one; numerator never exceeds denominator when crossed
    localparam int QB = FRAC_BITS + 1;
    localparam int NSTAGE = (QB + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int RB = NUM_BITS + 1;

    logic [RB-1:0]       r_rem  [NSTAGE];
    logic [NUM_BITS-1:0] r_den  [NSTAGE];
    logic [QB-1:0]       r_q    [NSTAGE];
    logic                r_zero [NSTAGE];

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        logic [RB-1:0]       c_rem;
        logic [NUM_BITS-1:0] c_den;
        logic [QB-1:0]       c_q;
        logic                c_zero;
        logic [RB-1:0]       n_rem;
        logic [QB-1:0]       n_q;
        if (s == 0) begin : g_head
            assign c_rem  = {1'b0, i_num};
            assign c_den  = i_den;
            assign c_q    = '0;
            assign c_zero = (i_den == '0);
        end else begin : g_body
            assign c_rem  = r_rem[s-1];
            assign c_den  = r_den[s-1];
            assign c_q    = r_q[s-1];
            assign c_zero = r_zero[s-1];
        end
        always_comb begin
            logic [RB:0] t;
            t     = '0;
            n_rem = c_rem;
            n_q   = c_q;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                if (s * STEPS_PER_STAGE + k < QB) begin
                    // first step compares remainder at weight 2^FRAC_BITS
                    if (s == 0 && k == 0) begin
                        t = {1'b0, n_rem};
                    end else begin
                        t = {n_rem, 1'b0};
                    end
                    if (t >= {2'b0, c_den}) begin
                        t = t - {2'b0, c_den};
                        n_q = {n_q[QB-2:0], 1'b1};
                    end else begin
                        n_q = {n_q[QB-2:0], 1'b0};
                    end
                    n_rem = t[RB-1:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= c_den;
                r_q[s]    <= n_q;
                r_zero[s] <= c_zero;
            end
        end
    end

    always_comb begin
        if (r_zero[NSTAGE-1]) begin
            o_quot = '0;
        end else if (r_q[NSTAGE-1] > QB'(1 << FRAC_BITS)) begin
            o_quot = QB'(1 << FRAC_BITS);
        end else begin
            o_quot = r_q[NSTAGE-1];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/marching_squares_cell.sv
// top level: marching squares cell with selectable saddle decider
//
// channel | dir | payload
// in      | in  | corner_ll/lr/ul/ur, cell_col, cell_row
// out     | out | start_x/y, end_x/y, last_segment
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// one cell per cycle for plain cells while the output is not stalled; a saddle
// cell holds the output stage for two words
// the stage chain moves when the output register is free and no second word waits
// a stall freezes all
// synchronous reset clears valid bits and registers only
`default_nettype none
module marching_squares_cell import msq_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int GRID_POINTS = GRID_POINTS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    msq_if.sink   in_if,
    msq_if.source out_if
);
    localparam int SB = SAMPLE_BITS;
    localparam int DB = SB + 1;
    localparam int QB = FRAC_BITS + 1;
    localparam int CB = IDX_BITS + FRAC_BITS + 1;
    localparam int PB = 2 * DB;
    localparam int DSTAGES = (QB + 3) / 4;
    localparam logic [CB-1:0] LIM = CB'(GRID_POINTS - 1) << FRAC_BITS;

    logic signed [SB-1:0] r_iso;
    logic                 r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso  <= '0;
            r_mode <= MODE_MIDPOINT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ISO_LEVEL:    r_iso  <= i_cfg_data[SB-1:0];
                REG_DECIDER_MODE: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic signed [SB-1:0] ll, lr, ul, ur;
    assign ll = in_if.data.corner_ll[SB-1:0];
    assign lr = in_if.data.corner_lr[SB-1:0];
    assign ul = in_if.data.corner_ul[SB-1:0];
    assign ur = in_if.data.corner_ur[SB-1:0];

    // stage 1: differences to iso, inside flags, magnitudes for the divider
    logic signed [DB-1:0] n_dll, n_dlr, n_dul, n_dur;
    assign n_dll = DB'(ll) - DB'(r_iso);
    assign n_dlr = DB'(lr) - DB'(r_iso);
    assign n_dul = DB'(ul) - DB'(r_iso);
    assign n_dur = DB'(ur) - DB'(r_iso);

    function automatic logic [DB-1:0] f_abs(input logic signed [DB-1:0] v);
        return v[DB-1] ? DB'(-v) : v;
    endfunction
    function automatic logic [DB-1:0] f_dist(input logic signed [SB-1:0] a,
                                             input logic signed [SB-1:0] b);
        logic signed [DB-1:0] d;
        d = DB'(b) - DB'(a);
        return d[DB-1] ? DB'(-d) : d;
    endfunction

    logic [DB-1:0] r_num [4];
    logic [DB-1:0] r_den [4];
    logic signed [DB-1:0] r_dll, r_dlr, r_dul, r_dur;
    logic [3:0] r_in1;
    logic [IDX_BITS-1:0] r_col1, r_row1;
    logic r_v1, r_mode1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= in_if.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num[0] <= f_abs(n_dll);  r_den[0] <= f_dist(ll, lr);
            r_num[1] <= f_abs(n_dul);  r_den[1] <= f_dist(ul, ur);
            r_num[2] <= f_abs(n_dll);  r_den[2] <= f_dist(ll, ul);
            r_num[3] <= f_abs(n_dlr);  r_den[3] <= f_dist(lr, ur);
            r_dll <= n_dll; r_dlr <= n_dlr; r_dul <= n_dul; r_dur <= n_dur;
            r_in1 <= {~n_dur[DB-1], ~n_dul[DB-1], ~n_dlr[DB-1], ~n_dll[DB-1]};
            r_col1 <= in_if.data.cell_col;
            r_row1 <= in_if.data.cell_row;
            r_mode1 <= r_mode;
        end
    end

    // stage 2: saddle products and sum, in parallel with the divider input registers
    logic [PB-1:0] r_pa, r_pb;
    logic signed [DB+1:0] r_sum;
    logic [3:0] r_in2;
    logic [IDX_BITS-1:0] r_col2, r_row2;
    logic r_v2, r_mode2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pa <= PB'(f_abs(r_dll)) * PB'(f_abs(r_dur));
            r_pb <= PB'(f_abs(r_dlr)) * PB'(f_abs(r_dul));
            r_sum <= (DB+2)'(r_dll) + (DB+2)'(r_dlr) + (DB+2)'(r_dul) + (DB+2)'(r_dur);
            r_in2 <= r_in1; r_col2 <= r_col1; r_row2 <= r_row1; r_mode2 <= r_mode1;
        end
    end

    // stage 3: centre decision; then delay to meet the divider outputs
    logic n_cen;
    always_comb begin
        if (r_mode2 == MODE_MIDPOINT) begin
            n_cen = !r_sum[DB+1];
        end else if (r_in2[0]) begin
            n_cen = (r_pa >= r_pb);
        end else begin
            n_cen = (r_pa <= r_pb);
        end
    end

    localparam int DLY = DSTAGES;
    logic [3:0]          r_inq  [DLY];
    logic [IDX_BITS-1:0] r_colq [DLY];
    logic [IDX_BITS-1:0] r_rowq [DLY];
    logic                r_cenq [DLY];
    logic                r_vq   [DLY];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) r_vq[i] <= 1'b0;
        end else if (adv) begin
            r_vq[0] <= r_v2;
            for (int i = 1; i < DLY; i++) r_vq[i] <= r_vq[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_inq[0] <= r_in2; r_colq[0] <= r_col2; r_rowq[0] <= r_row2;
            r_cenq[0] <= n_cen;
            for (int i = 1; i < DLY; i++) begin
                r_inq[i] <= r_inq[i-1]; r_colq[i] <= r_colq[i-1];
                r_rowq[i] <= r_rowq[i-1]; r_cenq[i] <= r_cenq[i-1];
            end
        end
    end

    // divider inputs registered once more, so quotients meet the last delay slot
    logic [QB-1:0] q_frac [4];
    logic [DB-1:0] r_numd [4];
    logic [DB-1:0] r_dend [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int e = 0; e < 4; e++) begin
                r_numd[e] <= r_num[e];
                r_dend[e] <= r_den[e];
            end
        end
    end
    for (genvar e = 0; e < 4; e++) begin : g_div
        msq_div #(.NUM_BITS(DB), .FRAC_BITS(FRAC_BITS), .STEPS_PER_STAGE(4)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r_numd[e]),
            .i_den (r_dend[e]),
            .o_quot(q_frac[e])
        );
    end

    // final stage: coordinates and segment selection
    function automatic logic [COORD_BITS-1:0] f_coord(input logic [IDX_BITS:0] idx,
                                                      input logic [QB-1:0] t);
        logic [CB-1:0] v;
        v = (CB'(idx) << FRAC_BITS) + CB'(t);
        if (v > LIM) v = LIM;
        return COORD_BITS'(v);
    endfunction

    logic [3:0] inq;
    logic [IDX_BITS:0] col, row;
    assign inq = r_inq[DLY-1];
    assign col = {1'b0, r_colq[DLY-1]};
    assign row = {1'b0, r_rowq[DLY-1]};

    logic [COORD_BITS-1:0] px [4];
    logic [COORD_BITS-1:0] py [4];
    logic [3:0] cr;
    always_comb begin
        px[EDGE_BOTTOM] = f_coord(col, q_frac[0]);  py[EDGE_BOTTOM] = f_coord(row, '0);
        px[EDGE_TOP]    = f_coord(col, q_frac[1]);  py[EDGE_TOP]    = f_coord(row + 1'b1, '0);
        px[EDGE_LEFT]   = f_coord(col, '0);         py[EDGE_LEFT]   = f_coord(row, q_frac[2]);
        px[EDGE_RIGHT]  = f_coord(col + 1'b1, '0);  py[EDGE_RIGHT]  = f_coord(row, q_frac[3]);
        cr[EDGE_BOTTOM] = inq[0] ^ inq[1];
        cr[EDGE_TOP]    = inq[2] ^ inq[3];
        cr[EDGE_LEFT]   = inq[0] ^ inq[2];
        cr[EDGE_RIGHT]  = inq[1] ^ inq[3];
    end

    logic [1:0] s0, e0, s1, e1;
    logic saddle;
    always_comb begin
        saddle = (cr == 4'b1111);
        s0 = EDGE_BOTTOM; e0 = EDGE_TOP; s1 = EDGE_TOP; e1 = EDGE_LEFT;
        if (saddle) begin
            if (r_cenq[DLY-1] == inq[0]) begin
                e0 = EDGE_RIGHT; e1 = EDGE_LEFT;
            end else begin
                e0 = EDGE_LEFT;  e1 = EDGE_RIGHT;
            end
        end else begin
            priority if (cr[EDGE_BOTTOM]) s0 = EDGE_BOTTOM;
            else if (cr[EDGE_TOP]) s0 = EDGE_TOP;
            else s0 = EDGE_LEFT;
            priority if (cr[EDGE_RIGHT]) e0 = EDGE_RIGHT;
            else if (cr[EDGE_LEFT]) e0 = EDGE_LEFT;
            else e0 = EDGE_TOP;
        end
    end

    // output register with a second word held for saddles
    logic r_ov, r_pend;
    logic [COORD_BITS-1:0] r_p1sx, r_p1sy, r_p1ex, r_p1ey;
    logic fin_v;
    assign fin_v = r_vq[DLY-1] && (cr != 4'b0000);
    logic out_free;
    assign out_free = !r_ov || out_if.ready;
    assign adv = out_free && !r_pend;
    assign in_if.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_ov <= 1'b1; r_pend <= 1'b0;
            end else begin
                r_ov <= fin_v; r_pend <= fin_v && saddle;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                out_if.data.start_x <= r_p1sx; out_if.data.start_y <= r_p1sy;
                out_if.data.end_x <= r_p1ex;   out_if.data.end_y <= r_p1ey;
                out_if.data.last_segment <= 1'b1;
            end else begin
                out_if.data.start_x <= px[s0]; out_if.data.start_y <= py[s0];
                out_if.data.end_x <= px[e0];   out_if.data.end_y <= py[e0];
                out_if.data.last_segment <= !saddle;
                r_p1sx <= px[s1]; r_p1sy <= py[s1];
                r_p1ex <= px[e1]; r_p1ey <= py[e1];
            end
        end
    end
    assign out_if.valid = r_ov;
endmodule
`default_nettype wire

### hw/rtl/msq_checker.sv
// port-level checker for the marching squares cell, bound to the top level
`default_nettype none
module msq_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("word dropped");
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_last |=> out_valid && out_last)
        else $error("saddle second word missing");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("valid after reset");
endmodule

bind marching_squares_cell msq_checker u_msq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_last(out_if.data.last_segment)
);
`default_nettype wire

### tb/marching_squares_cell_test.sv
// self-checking testbench for the marching squares cell
`default_nettype none
module marching_squares_cell_test;
    import msq_pkg::*;

    typedef struct packed {
        logic signed [15:0] corner_ll;
        logic signed [15:0] corner_lr;
        logic signed [15:0] corner_ul;
        logic signed [15:0] corner_ur;
        logic [IDX_BITS-1:0] cell_col;
        logic [IDX_BITS-1:0] cell_row;
    } t_cell;

    typedef struct packed {
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic                  last_segment;
    } t_seg;

    localparam int CELL_BITS = $bits(t_cell);

    class segment_board;
        t_seg   pending[$];
        longint iso;
        bit     mode;
        int     errors;

        function longint magn(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint crossing(longint a, longint b);
            longint ud, t;
            ud = magn(b - a);
            if (ud == 0) return 0;
            t = (magn(iso - a) << FRAC_BITS_DEF) / ud;
            return t > (1 << FRAC_BITS_DEF) ? (1 << FRAC_BITS_DEF) : t;
        endfunction

        function longint grid_pos(longint idx, longint t);
            longint v, lim;
            lim = longint'(GRID_POINTS_DEF - 1) << FRAC_BITS_DEF;
            v = (idx << FRAC_BITS_DEF) + t;
            return v > lim ? lim : v;
        endfunction

        function void note(t_cell c);
            longint ll, lr, ul, ur, col, row;
            longint px[4], py[4];
            bit il, ir, iu, iv, cr[4], centre;
            int edges[4], n, nseg;
            t_seg s;
            ll = longint'(c.corner_ll); lr = longint'(c.corner_lr);
            ul = longint'(c.corner_ul); ur = longint'(c.corner_ur);
            col = longint'(c.cell_col); row = longint'(c.cell_row);
            il = ll >= iso; ir = lr >= iso; iu = ul >= iso; iv = ur >= iso;
            cr[EDGE_BOTTOM] = il != ir; cr[EDGE_TOP] = iu != iv;
            cr[EDGE_LEFT] = il != iu; cr[EDGE_RIGHT] = ir != iv;
            px[EDGE_BOTTOM] = grid_pos(col, crossing(ll, lr));
            py[EDGE_BOTTOM] = grid_pos(row, 0);
            px[EDGE_TOP] = grid_pos(col, crossing(ul, ur));
            py[EDGE_TOP] = grid_pos(row + 1, 0);
            px[EDGE_LEFT] = grid_pos(col, 0);
            py[EDGE_LEFT] = grid_pos(row, crossing(ll, ul));
            px[EDGE_RIGHT] = grid_pos(col + 1, 0);
            py[EDGE_RIGHT] = grid_pos(row, crossing(lr, ur));
            n = 0;
            for (int k = 0; k < 4; k++)
                if (cr[k]) begin
                    edges[n] = k;
                    n++;
                end
            if (n == 0) return;
            nseg = 1;
            if (n == 4) begin
                nseg = 2;
                if (mode == MODE_MIDPOINT) begin
                    centre = (ll + lr + ul + ur) >= 4 * iso;
                end else begin
                    longint p1, p2;
                    p1 = magn(ll - iso) * magn(ur - iso);
                    p2 = magn(lr - iso) * magn(ul - iso);
                    centre = il ? (p1 >= p2) : (p1 <= p2);
                end
                edges[0] = EDGE_BOTTOM; edges[2] = EDGE_TOP;
                edges[1] = (centre == il) ? EDGE_RIGHT : EDGE_LEFT;
                edges[3] = (centre == il) ? EDGE_LEFT : EDGE_RIGHT;
            end
            for (int k = 0; k < nseg; k++) begin
                s.start_x = COORD_BITS'(px[edges[2*k]]);
                s.start_y = COORD_BITS'(py[edges[2*k]]);
                s.end_x = COORD_BITS'(px[edges[2*k+1]]);
                s.end_y = COORD_BITS'(py[edges[2*k+1]]);
                s.last_segment = (k == nseg - 1);
                pending = {pending, s};
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(t_seg got);
            t_seg want;
            if (pending.size() == 0) begin
                $display("unexpected word: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.start_x !== want.start_x)
                report("start_x", longint'(got.start_x), longint'(want.start_x));
            if (got.start_y !== want.start_y)
                report("start_y", longint'(got.start_y), longint'(want.start_y));
            if (got.end_x !== want.end_x)
                report("end_x", longint'(got.end_x), longint'(want.end_x));
            if (got.end_y !== want.end_y)
                report("end_y", longint'(got.end_y), longint'(want.end_y));
            if (got.last_segment !== want.last_segment)
                report("last_segment", longint'(got.last_segment),
                       longint'(want.last_segment));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = REG_ISO_LEVEL;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    int in_idle = 0, out_idle = 0;
    segment_board board = new();

    msq_if #(.t_payload(t_cell)) in_ch();
    msq_if #(.t_payload(t_seg))  out_ch();

    marching_squares_cell dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_if(in_ch.sink), .out_if(out_ch.source)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= out_idle);
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) board.note(in_ch.data);
            if (out_ch.valid && out_ch.ready) board.check(out_ch.data);
        end
    end

    task send_cell(t_cell c);
        while ($urandom_range(99) < in_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= c;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // hold the sender until every word is out and the pipe has emptied
    task drain;
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == REG_ISO_LEVEL) board.iso = longint'($signed(val));
        else board.mode = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function logic [15:0] near_iso(longint d);
        longint v;
        v = board.iso + d;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function t_cell make(int a, int b, int c, int d, int col, int row);
        t_cell x;
        x.corner_ll = 16'(a); x.corner_lr = 16'(b);
        x.corner_ul = 16'(c); x.corner_ur = 16'(d);
        x.cell_col = IDX_BITS'(col); x.cell_row = IDX_BITS'(row);
        return x;
    endfunction

    function t_cell random_cell();
        t_cell c;
        int span, shape;
        longint s;
        c = CELL_BITS'({$urandom, $urandom, $urandom});
        shape = $urandom_range(3);
        span = $urandom_range(1) ? 300 : 40000;
        if (shape == 1) begin
            c.corner_ll = near_iso(longint'($urandom_range(2*span)) - span);
            c.corner_lr = near_iso(longint'($urandom_range(2*span)) - span);
            c.corner_ul = near_iso(longint'($urandom_range(2*span)) - span);
            c.corner_ur = near_iso(longint'($urandom_range(2*span)) - span);
        end else if (shape >= 2) begin
            // saddle: diagonal pairs on opposite sides
            s = $urandom_range(1) ? 1 : -1;
            c.corner_ll = near_iso(s > 0 ? longint'($urandom_range(span))
                                         : -1 - longint'($urandom_range(span)));
            c.corner_ur = near_iso(s > 0 ? longint'($urandom_range(span))
                                         : -1 - longint'($urandom_range(span)));
            c.corner_lr = near_iso(s < 0 ? longint'($urandom_range(span))
                                         : -1 - longint'($urandom_range(span)));
            c.corner_ul = near_iso(s < 0 ? longint'($urandom_range(span))
                                         : -1 - longint'($urandom_range(span)));
        end
        if ($urandom_range(7) != 0) begin
            c.cell_col = IDX_BITS'($urandom_range(1021));
            c.cell_row = IDX_BITS'($urandom_range(1021));
        end
        return c;
    endfunction

    initial begin
        logic [15:0] isos[8];
        bit modes[8];
        bit ok;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(REG_ISO_LEVEL, 16'sd0);
        write_reg(REG_DECIDER_MODE, 16'(MODE_MIDPOINT));

        // uniform cells, extremes, single crossings on each edge pair, saddles
        send_cell(make(100, 200, 300, 400, 5, 5));
        send_cell(make(-100, -200, -300, -400, 5, 5));
        send_cell(make(-32768, 32767, -32768, 32767, 0, 0));
        send_cell(make(32767, -32768, 32767, -32768, 1023, 1023));
        send_cell(make(-10, 30, -10, -10, 1022, 1022));
        send_cell(make(-10, -10, 30, -10, 1023, 0));
        send_cell(make(-10, -10, -10, 30, 0, 1023));
        send_cell(make(0, -1, -1, -1, 7, 9));
        send_cell(make(-1, 0, 0, 0, 7, 9));
        send_cell(make(-32768, -32768, 32767, 32767, 512, 256));
        send_cell(make(10, -10, -10, 10, 3, 4));
        send_cell(make(10, -30, -30, 10, 3, 4));
        send_cell(make(-10, 30, 30, -10, 3, 4));
        send_cell(make(-30, 10, 10, -30, 3, 4));
        send_cell(make(32767, -32768, -32768, 32767, 1023, 1023));
        send_cell(make(-32768, 32767, 32767, -32768, 1022, 0));
        drain();
        write_reg(REG_DECIDER_MODE, 16'(MODE_ASYMPTOTIC));
        send_cell(make(10, -10, -10, 10, 3, 4));
        send_cell(make(10, -30, -30, 10, 3, 4));
        send_cell(make(100, -1, -1, 1, 3, 4));
        send_cell(make(-10, 30, 30, -10, 3, 4));
        send_cell(make(-1, 100, 100, -1, 3, 4));
        send_cell(make(32767, -32768, -32768, 32767, 1023, 1023));
        drain();

        isos = '{16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        for (int p = 0; p < 8; p++) begin
            if (p >= 3) isos[p] = 16'($urandom);
            write_reg(REG_ISO_LEVEL, isos[p]);
            write_reg(REG_DECIDER_MODE, 16'(modes[p]));
            in_idle = (p < 3) ? 34 : (p < 6) ? 57 : 0;
            out_idle = (p < 3) ? 57 : (p < 6) ? 34 : 0;
            // an all-inside threshold gives nothing, keep that phase short
            for (int i = 0; i < (p == 1 ? 15 : 55); i++) send_cell(random_cell());
            drain();
        end

        ok = (board.errors == 0) && (board.pending.size() == 0);
        if (ok) $display("marching_squares_cell regression: pass");
        else $display("marching_squares_cell regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("marching_squares_cell regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
